/* src/sb7_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sb7_pkg;

   localparam int TAPS      = 7;
   localparam int LINES     = TAPS - 1;
   localparam int PIX_W     = 8;
   localparam int DIM_W     = 11;
   localparam int SLOT_W    = 3;
   localparam int SUM_W     = 16;
   localparam int SUM_SHIFT = 8;
   localparam int OUT_DEPTH = 3;
   localparam int PTR_W     = 2;
   localparam int CNT_W     = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

   localparam logic            CSR_FRAME_WIDTH  = 1'b0;
   localparam logic            CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [TAPS-1:0][6:0] TAP_WEIGHT =
      {7'd2, 7'd15, 7'd62, 7'd98, 7'd62, 7'd15, 7'd2};

   typedef logic [TAPS-1:0][PIX_W-1:0] tap_vec_type;

   typedef struct packed {
      logic             frame_end;
      logic             row_end;
      logic [PIX_W-1:0] pixel;
   } rsp_beat_type;

   // Weighted sum of seven pixels, index 0 being the oldest, scaled down by 256.
   function automatic logic [PIX_W-1:0] tap_sum(input tap_vec_type taps);
      logic [SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
         acc = acc + SUM_W'(TAP_WEIGHT[i]) * SUM_W'(taps[i]);
      end
      return acc[SUM_SHIFT +: PIX_W];
   endfunction

endpackage

`default_nettype wire

/* src/sb7_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sb7_ram #(
   parameter int DATA_W = 48,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/sb7_hfilter.sv */
`timescale 1ns / 1ps
`default_nettype none

module sb7_hfilter (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift_en,
   input  wire logic [sb7_pkg::PIX_W-1:0]  pixel,
   output logic      [sb7_pkg::PIX_W-1:0]  hval
);

   logic [sb7_pkg::LINES-1:0][sb7_pkg::PIX_W-1:0] window_ff;
   logic [sb7_pkg::LINES-1:0][sb7_pkg::PIX_W-1:0] window_in;
   sb7_pkg::tap_vec_type                          taps;

   always_comb begin
      window_in = {pixel, window_ff[sb7_pkg::LINES-1:1]};
      taps      = {pixel, window_ff};
      hval      = sb7_pkg::tap_sum(taps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (shift_en) begin
         window_ff <= window_in;
      end
   end

endmodule

`default_nettype wire

/* src/sb7_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module sb7_out_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire sb7_pkg::rsp_beat_type     push_beat,
   input  wire logic                      pop,
   output sb7_pkg::rsp_beat_type          head_beat,
   output logic      [sb7_pkg::CNT_W-1:0] count
);

   sb7_pkg::rsp_beat_type             mem_ff [sb7_pkg::OUT_DEPTH];
   logic [sb7_pkg::PTR_W-1:0]         head_ff, head_in;
   logic [sb7_pkg::PTR_W-1:0]         tail_ff, tail_in;
   logic [sb7_pkg::CNT_W-1:0]         count_ff, count_in;

   localparam logic [sb7_pkg::PTR_W-1:0] LAST_PTR = sb7_pkg::PTR_W'(sb7_pkg::OUT_DEPTH - 1);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_beat;
      end
   end

   assign head_beat = mem_ff[head_ff];
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < sb7_pkg::CNT_W'(sb7_pkg::OUT_DEPTH)) || pop)
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue underflow");

endmodule

`default_nettype wire

/* src/separable_7tap_image_blur.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                                        Beat
// request    req_tvalid/req_tready/req_tdata              one input pixel, raster order
// response   rsp_tvalid/rsp_tready/rsp_tdata/tlast/tuser  filtered pixel, row end, frame end
// register   csr_valid/csr_ready/csr_index/csr_data       width (0) or height (1) write
//
// One pixel is taken per clock while the queue has room; the line memory is read on
// acceptance and written back in the next cycle, as the filter stage pushes its result into the queue.
// Results wait in a three-entry queue; the input stalls only while the queued results
// plus the one in the filter stage fill all three entries.
// Reset clears positions, window and queue; the line memory needs no clearing.

module separable_7tap_image_blur #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [7:0]                  req_tdata,   // pixel_in[7:0]
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [7:0]                  rsp_tdata,   // pixel_out[7:0]
   output logic                             rsp_tlast,   // row_end
   output logic                             rsp_tuser,   // frame_end
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [sb7_pkg::DIM_W-1:0]   csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WL_W   = COL_W + 1;
   localparam int HL_W   = ROW_W + 1;
   localparam int SLOT_W = sb7_pkg::SLOT_W;
   localparam int PIX_W  = sb7_pkg::PIX_W;
   localparam int LINE_W = sb7_pkg::LINES * PIX_W;
   localparam int OCC_W  = sb7_pkg::CNT_W + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(sb7_pkg::LINES - 1);

   logic [sb7_pkg::DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;

   logic [WL_W-1:0]           width_lim;
   logic [HL_W-1:0]           height_lim;
   logic                      last_col, last_row, tap_active, row_active, accept;
   logic [COL_W-1:0]          hx;
   logic [PIX_W-1:0]          hval;

   logic                      s1_valid_ff, s1_write_ff;
   logic [PIX_W-1:0]          s1_hval_ff;
   logic [COL_W-1:0]          s1_addr_ff;
   logic [SLOT_W-1:0]         s1_slot_ff;
   logic                      s1_row_end_ff, s1_frame_end_ff;

   logic [LINE_W-1:0]         line_rd;
   logic [LINE_W-1:0]         line_wr;
   sb7_pkg::tap_vec_type      vtaps;
   sb7_pkg::rsp_beat_type     s1_beat, head_beat;
   logic [sb7_pkg::CNT_W-1:0] out_count;
   logic [OCC_W-1:0]          in_flight;
   logic [SLOT_W:0]           tap_slot;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sb7_pkg::DIM_RESET;
         frame_height_ff <= sb7_pkg::DIM_RESET;
      end else if (csr_valid) begin
         if (csr_index == sb7_pkg::CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_data;
         end else begin
            frame_height_ff <= csr_data;
         end
      end
   end

   always_comb begin
      if (frame_width_ff < sb7_pkg::DIM_W'(sb7_pkg::TAPS)) begin
         width_lim = WL_W'(sb7_pkg::TAPS);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         width_lim = WL_W'(MAX_WIDTH);
      end else begin
         width_lim = WL_W'(frame_width_ff);
      end
      if (frame_height_ff < sb7_pkg::DIM_W'(sb7_pkg::TAPS)) begin
         height_lim = HL_W'(sb7_pkg::TAPS);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         height_lim = HL_W'(MAX_HEIGHT);
      end else begin
         height_lim = HL_W'(frame_height_ff);
      end
   end

   assign in_flight  = {1'b0, out_count} + OCC_W'(s1_valid_ff);
   assign req_tready = in_flight < OCC_W'(sb7_pkg::OUT_DEPTH);
   assign accept     = req_tvalid && req_tready;

   assign last_col   = (WL_W'(col_ff) + WL_W'(1)) >= width_lim;
   assign last_row   = (HL_W'(row_ff) + HL_W'(1)) >= height_lim;
   assign tap_active = col_ff >= COL_W'(sb7_pkg::LINES);
   assign row_active = row_ff >= ROW_W'(sb7_pkg::LINES);
   assign hx         = col_ff - COL_W'(sb7_pkg::LINES);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         slot_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_write_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         slot_ff     <= slot_in;
         s1_valid_ff <= accept && tap_active && row_active;
         s1_write_ff <= accept && tap_active;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hval_ff      <= hval;
         s1_addr_ff      <= hx;
         s1_slot_ff      <= slot_ff;
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
      end
   end

   sb7_hfilter u_hfilter (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .pixel    (req_tdata),
      .hval     (hval)
   );

   sb7_ram #(
      .DATA_W (LINE_W),
      .ADDR_W (COL_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_write_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr),
      .rd_en   (accept && tap_active),
      .rd_addr (hx),
      .rd_data (line_rd)
   );

   // The slot of the current row holds the oldest line; it feeds the first tap
   // and is then replaced by the new horizontal result.
   always_comb begin
      line_wr = line_rd;
      line_wr[s1_slot_ff*PIX_W +: PIX_W] = s1_hval_ff;
      for (int i = 0; i < sb7_pkg::LINES; i++) begin
         tap_slot = {1'b0, s1_slot_ff} + (SLOT_W + 1)'(i);
         if (tap_slot >= (SLOT_W + 1)'(sb7_pkg::LINES)) begin
            tap_slot = tap_slot - (SLOT_W + 1)'(sb7_pkg::LINES);
         end
         vtaps[i] = line_rd[tap_slot[SLOT_W-1:0]*PIX_W +: PIX_W];
      end
      vtaps[sb7_pkg::LINES] = s1_hval_ff;
      s1_beat.pixel     = sb7_pkg::tap_sum(vtaps);
      s1_beat.row_end   = s1_row_end_ff;
      s1_beat.frame_end = s1_frame_end_ff;
   end

   sb7_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_beat (s1_beat),
      .pop       (rsp_tvalid && rsp_tready),
      .head_beat (head_beat),
      .count     (out_count)
   );

   assign rsp_tvalid = out_count != '0;
   assign rsp_tdata  = head_beat.pixel;
   assign rsp_tlast  = head_beat.row_end;
   assign rsp_tuser  = head_beat.frame_end;

   a_result_writes_line: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_write_ff)
      else $error("result without line memory write back");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("line slot out of range");

   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      (accept && tap_active && row_active) |=> s1_valid_ff)
      else $error("filtered pixel lost");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && last_col && last_row) |=> (col_ff == '0 && row_ff == '0 && slot_ff == '0))
      else $error("position not cleared at frame end");

endmodule

`default_nettype wire
